// ----- hw/rtl/tilog_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the time indexed log search core
// no dependencies

package tilog_pkg;

   localparam int DEPTH    = 1024;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam int MODE_W   = 2;
   localparam int TIME_W   = 48;
   localparam int ITER_W   = 32;
   localparam int HANDLE_W = 16;
   localparam int RIDX_W   = 10;
   localparam int CMP_W    = RIDX_W + CNT_W;

   localparam int ENTRY_W  = TIME_W + ITER_W + HANDLE_W;

   localparam int REQ_TDATA_W = ((TIME_W + ITER_W + HANDLE_W + RIDX_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W = MODE_W;
   localparam int RSP_TDATA_W = ((RIDX_W + HANDLE_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_TIME   = 2'd1,
      MODE_ITER   = 2'd2,
      MODE_INDEX  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_STEP,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/tilog_ram.sv -----
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module tilog_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/time_indexed_log_search_core.sv -----
`timescale 1ns / 1ps
// append-only time/iteration log with binary floor search, uses tilog_pkg and tilog_ram
// flow: a request is captured in idle and decided next; appends, empty or clamped lookups and iteration
// misses go to done, an in-range index read passes through fetch, a search through its steps then fetch
// one transaction at a time: no new request is taken until the result is staged, which waits
// while the previous result is held; one ram read and one compare per search step
// reset: synchronous, empties the log and clears control; ram contents are not cleared

module time_indexed_log_search_core (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: time_value[47:0], iteration_value[79:48], entry_handle[95:80], read_index[105:96]
   input  logic [tilog_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: mode[1:0]
   input  logic [tilog_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: result_index[9:0], result_handle[25:10], result_time[73:26]
   output logic [tilog_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser: accepted[0], found[1]
   output logic [tilog_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   import tilog_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TIME_W-1:0]     first_time_ff, first_time_in;
   logic [ITER_W-1:0]     first_iter_ff, first_iter_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   logic [ITER_W-1:0]     last_iter_ff, last_iter_in;

   mode_type              mode_ff, mode_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [RIDX_W-1:0]     rdx_ff, rdx_in;

   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [IDX_W-1:0]      mid_ff, mid_in;

   logic                  res_acc_ff, res_acc_in;
   logic                  res_fnd_ff, res_fnd_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   logic [HANDLE_W-1:0]   res_hnd_ff, res_hnd_in;
   logic [TIME_W-1:0]     res_time_ff, res_time_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;

   logic [TIME_W-1:0]     rd_time;
   logic [ITER_W-1:0]     rd_iter;
   logic [HANDLE_W-1:0]   rd_handle;
   logic [TIME_W-1:0]     cmp_key;
   logic [TIME_W-1:0]     cmp_qry;
   logic                  key_le;

   logic [CNT_W-1:0]      lo_sel;
   logic [CNT_W-1:0]      hi_sel;
   logic [CNT_W:0]        mid_sum;
   logic [IDX_W-1:0]      mid_calc;
   logic                  span_gt1;
   logic [IDX_W-1:0]      last_idx;
   logic                  append_ok;
   logic                  search_go;

   tilog_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_time   = ram_rdata[ENTRY_W-1 -: TIME_W];
   assign rd_iter   = ram_rdata[HANDLE_W +: ITER_W];
   assign rd_handle = ram_rdata[HANDLE_W-1:0];

   // shared compare unit
   assign cmp_key = (mode_ff == MODE_TIME) ? rd_time : TIME_W'(rd_iter);
   assign cmp_qry = (mode_ff == MODE_TIME) ? time_ff : TIME_W'(iter_ff);
   assign key_le  = cmp_key <= cmp_qry;

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_time_ff <= first_time_in;
      first_iter_ff <= first_iter_in;
      last_time_ff  <= last_time_in;
      last_iter_ff  <= last_iter_in;
      mode_ff       <= mode_in;
      time_ff       <= time_in;
      iter_ff       <= iter_in;
      handle_ff     <= handle_in;
      rdx_ff        <= rdx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_acc_ff    <= res_acc_in;
      res_fnd_ff    <= res_fnd_in;
      res_idx_ff    <= res_idx_in;
      res_hnd_ff    <= res_hnd_in;
      res_time_ff   <= res_time_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      first_time_in = first_time_ff;
      first_iter_in = first_iter_ff;
      last_time_in  = last_time_ff;
      last_iter_in  = last_iter_ff;
      mode_in       = mode_ff;
      time_in       = time_ff;
      iter_in       = iter_ff;
      handle_in     = handle_ff;
      rdx_in        = rdx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_acc_in    = res_acc_ff;
      res_fnd_in    = res_fnd_ff;
      res_idx_in    = res_idx_ff;
      res_hnd_in    = res_hnd_ff;
      res_time_in   = res_time_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      ram_we    = 1'b0;
      ram_waddr = count_ff[IDX_W-1:0];
      ram_wdata = {time_ff, iter_ff, handle_ff};
      ram_raddr = mid_ff;
      req_tready = (state_ff == ST_IDLE);
      search_go  = 1'b0;
      append_ok  = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // next search bounds: start of search or one step of it
      if (state_ff == ST_STEP) begin
         lo_sel = key_le ? CNT_W'(mid_ff) : lo_ff;
         hi_sel = key_le ? hi_ff : CNT_W'(mid_ff);
      end else begin
         lo_sel = '0;
         hi_sel = count_ff;
      end
      mid_sum  = (CNT_W+1)'(lo_sel) + (CNT_W+1)'(hi_sel);
      mid_calc = IDX_W'(mid_sum >> 1);
      span_gt1 = (hi_sel - lo_sel) > CNT_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = mode_type'(req_tuser[MODE_W-1:0]);
               time_in   = req_tdata[TIME_W-1:0];
               iter_in   = req_tdata[TIME_W +: ITER_W];
               handle_in = req_tdata[TIME_W+ITER_W +: HANDLE_W];
               rdx_in    = req_tdata[TIME_W+ITER_W+HANDLE_W +: RIDX_W];
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_acc_in  = 1'b0;
            res_fnd_in  = 1'b0;
            res_idx_in  = '0;
            res_hnd_in  = '0;
            res_time_in = '0;
            state_in    = ST_DONE;
            if (mode_ff == MODE_APPEND) begin
               append_ok = (count_ff < CNT_W'(DEPTH)) &&
                  !((count_ff != '0) && ((last_time_ff > time_ff) ||
                  ((iter_ff != '0) && (last_iter_ff > iter_ff))));
               if (append_ok) begin
                  ram_we       = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
                  last_time_in = time_ff;
                  last_iter_in = iter_ff;
                  if (count_ff == '0) begin
                     first_time_in = time_ff;
                     first_iter_in = iter_ff;
                  end
                  res_acc_in = 1'b1;
                  res_idx_in = count_ff[IDX_W-1:0];
               end
            end else if (count_ff != '0) begin
               unique case (mode_ff)
                  MODE_TIME: begin
                     if (time_ff <= first_time_ff) begin
                        res_time_in = first_time_ff;
                     end else if (time_ff >= last_time_ff) begin
                        res_idx_in  = last_idx;
                        res_time_in = last_time_ff;
                     end else begin
                        search_go = 1'b1;
                     end
                  end
                  MODE_ITER: begin
                     if ((iter_ff >= first_iter_ff) && (iter_ff <= last_iter_ff)) begin
                        search_go = 1'b1;
                     end
                  end
                  MODE_INDEX: begin
                     if (CMP_W'(rdx_ff) < CMP_W'(count_ff)) begin
                        ram_raddr  = IDX_W'(rdx_ff);
                        res_idx_in = IDX_W'(rdx_ff);
                        state_in   = ST_FETCH;
                     end else begin
                        res_idx_in  = last_idx;
                        res_time_in = last_time_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STEP: begin
            search_go = 1'b1;
         end
         ST_FETCH: begin
            res_fnd_in  = 1'b1;
            res_hnd_in  = rd_handle;
            res_time_in = rd_time;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {res_fnd_ff, res_acc_ff};
               rsp_data_in  = RSP_TDATA_W'({res_time_ff, res_hnd_ff, RIDX_W'(res_idx_ff)});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (search_go) begin
         lo_in = lo_sel;
         hi_in = hi_sel;
         if (span_gt1) begin
            ram_raddr = mid_calc;
            mid_in    = mid_calc;
            state_in  = ST_STEP;
         end else begin
            ram_raddr  = lo_sel[IDX_W-1:0];
            res_idx_in = lo_sel[IDX_W-1:0];
            state_in   = ST_FETCH;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DECIDE || mode_ff != MODE_APPEND) |=> $stable(count_ff))
      else $error("entry count changed outside an append");

   a_write_when: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_DECIDE && mode_ff == MODE_APPEND && !count_ff[CNT_W-1 -: 1]
         || ram_we && state_ff == ST_DECIDE && CNT_W'(DEPTH) > count_ff))
      else $error("entry ram written outside an accepted append");

   a_step_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (lo_ff < CNT_W'(mid_ff)) && (CNT_W'(mid_ff) < hi_ff))
      else $error("search midpoint outside its bounds");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result staged without a finished transaction");
`endif

endmodule

// ----- tb/tilog_check_pkg.sv -----
`timescale 1ns / 1ps
// lookup predictor and result checker for the time indexed log search core
// depends on tilog_pkg for widths, depth and the mode enum

package tilog_check_pkg;

   import tilog_pkg::*;

   typedef struct packed {
      logic                accepted;
      logic                found;
      logic [RIDX_W-1:0]   pos;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   stamp;
   } lookup_result_type;

   class log_lookup_checker;

      logic [TIME_W-1:0]   time_log   [DEPTH];
      logic [ITER_W-1:0]   iter_log   [DEPTH];
      logic [HANDLE_W-1:0] handle_log [DEPTH];
      int                  count;
      logic [ITER_W-1:0]   top_iter;
      lookup_result_type   expected_lookups [$];
      int                  errors;
      int                  checked;

      function new();
         count    = 0;
         top_iter = '0;
         errors   = 0;
         checked  = 0;
      endfunction

      // highest position whose key is at or below the query
      function int floor_pick(logic [TIME_W-1:0] query, bit by_time);
         int                lo;
         int                hi;
         int                mid;
         logic [TIME_W-1:0] key;
         lo = 0;
         hi = count;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            key = by_time ? time_log[mid] : TIME_W'(iter_log[mid]);
            if (key <= query) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void predict_lookup(mode_type mode, logic [TIME_W-1:0] stamp,
                                   logic [ITER_W-1:0] iter, logic [HANDLE_W-1:0] handle,
                                   logic [RIDX_W-1:0] read_pos);
         lookup_result_type r;
         int                last;
         int                pick;
         bit                ok;
         r    = '0;
         last = count - 1;
         pick = 0;
         if (mode == MODE_APPEND) begin
            ok = (count < DEPTH);
            if (ok && count != 0) begin
               if (time_log[last] > stamp) ok = 0;
               if (iter != 0 && iter_log[last] > iter) ok = 0;
            end
            if (ok) begin
               time_log[count]   = stamp;
               iter_log[count]   = iter;
               handle_log[count] = handle;
               r.accepted        = 1'b1;
               r.pos             = RIDX_W'(count);
               count++;
               if (iter > top_iter) top_iter = iter;
            end
         end else if (count != 0) begin
            case (mode)
               MODE_TIME: begin
                  if (stamp <= time_log[0]) begin
                     pick = 0;
                  end else if (stamp >= time_log[last]) begin
                     pick = last;
                  end else begin
                     pick     = floor_pick(stamp, 1'b1);
                     r.found  = 1'b1;
                     r.handle = handle_log[pick];
                  end
                  r.pos   = RIDX_W'(pick);
                  r.stamp = time_log[pick];
               end
               MODE_ITER: begin
                  if (iter >= iter_log[0] && iter <= iter_log[last]) begin
                     pick     = floor_pick(TIME_W'(iter), 1'b0);
                     r.found  = 1'b1;
                     r.pos    = RIDX_W'(pick);
                     r.handle = handle_log[pick];
                     r.stamp  = time_log[pick];
                  end
               end
               default: begin
                  if (int'(read_pos) < count) begin
                     pick     = read_pos;
                     r.found  = 1'b1;
                     r.handle = handle_log[pick];
                  end else begin
                     pick = last;
                  end
                  r.pos   = RIDX_W'(pick);
                  r.stamp = time_log[pick];
               end
            endcase
         end
         expected_lookups = {expected_lookups, r};
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_lookup(logic [RSP_TUSER_W-1:0] user, logic [RSP_TDATA_W-1:0] data);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            errors++;
            $display("%0t: result with no pending transaction, expected none, actual tuser=%h tdata=%h",
                     $time, user, data);
            return;
         end
         want = expected_lookups.pop_front();
         checked++;
         compare_field("accepted", TIME_W'(want.accepted), TIME_W'(user[0]));
         compare_field("found", TIME_W'(want.found), TIME_W'(user[1]));
         compare_field("result_index", TIME_W'(want.pos), TIME_W'(data[9:0]));
         compare_field("result_handle", TIME_W'(want.handle), TIME_W'(data[25:10]));
         compare_field("result_time", want.stamp, data[73:26]);
      endfunction

   endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for time_indexed_log_search_core: directed and random lookups
// under four handshake pressure phases; depends on tilog_pkg and tilog_check_pkg

module tb_top;

   import tilog_pkg::*;
   import tilog_check_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_ITEMS  = 380;
   localparam int DRAIN_CYCLES = 20;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   log_lookup_checker sb = new();

   int cycle_count    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // sender view of the log tail, assuming well-formed appends land
   int                planned_count = 0;
   logic [TIME_W-1:0] tail_time     = '0;
   logic [ITER_W-1:0] tail_iter     = '0;
   logic [ITER_W-1:0] top_iter      = '0;

   time_indexed_log_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready  <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_lookup(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) begin
            sb.predict_lookup(mode_type'(req_tuser), req_tdata[47:0], req_tdata[79:48],
                              req_tdata[95:80], req_tdata[105:96]);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_item(mode_type mode, logic [TIME_W-1:0] stamp, logic [ITER_W-1:0] iter,
                            logic [HANDLE_W-1:0] handle, logic [RIDX_W-1:0] read_pos);
      logic [REQ_TDATA_W-1:0] data;
      data          = '0;
      data[47:0]    = stamp;
      data[79:48]   = iter;
      data[95:80]   = handle;
      data[105:96]  = read_pos;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tuser  <= mode;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // sender holds off until every pending result is back, then resyncs its tail view
   task automatic settle_log();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_lookups.size() != 0) @(posedge clock);
      planned_count = sb.count;
      top_iter      = sb.top_iter;
      if (sb.count > 0) begin
         tail_time = sb.time_log[sb.count-1];
         tail_iter = sb.iter_log[sb.count-1];
      end
   endtask

   function automatic logic [TIME_W-1:0] next_append_time();
      logic [TIME_W:0] total;
      int              s;
      s = $urandom_range(0, 99);
      if (s < 10) begin
         total = {1'b0, tail_time};
      end else if (s < 40) begin
         total = tail_time + $urandom_range(1, 16);
      end else begin
         total = tail_time + $urandom;
      end
      return total[TIME_W] ? '1 : total[TIME_W-1:0];
   endfunction

   function automatic logic [ITER_W-1:0] next_append_iter();
      if ($urandom_range(0, 99) < 15) return '0;
      if (top_iter > 32'hFFFF_FFF0) return top_iter;
      return top_iter + $urandom_range(0, 3);
   endfunction

   task automatic send_wellformed(logic [TIME_W-1:0] stamp, logic [ITER_W-1:0] iter);
      if (planned_count < DEPTH) begin
         planned_count++;
         tail_time = stamp;
         tail_iter = iter;
         if (iter != 0) top_iter = iter;
      end
      send_item(MODE_APPEND, stamp, iter, HANDLE_W'($urandom), RIDX_W'($urandom));
   endtask

   task automatic send_random_item();
      int                r;
      int                q;
      int                k;
      int                n;
      logic [63:0]       wide;
      logic [TIME_W-1:0] stamp;
      logic [ITER_W-1:0] iter;
      logic [RIDX_W-1:0] read_pos;
      wide     = {$urandom, $urandom};
      stamp    = wide[TIME_W-1:0];
      iter     = $urandom;
      read_pos = RIDX_W'($urandom);
      n        = sb.count;
      k        = (n > 0) ? $urandom_range(0, n - 1) : 0;
      r        = $urandom_range(0, 99);
      q        = $urandom_range(0, 9);
      if (r < 65) begin
         if (planned_count == 0 || $urandom_range(0, 99) < 88) begin
            send_wellformed(next_append_time(), next_append_iter());
         end else if (tail_iter > 1 && q < 5) begin
            // iteration runs backwards
            send_item(MODE_APPEND, tail_time, $urandom_range(1, tail_iter - 1),
                      HANDLE_W'($urandom), read_pos);
         end else if (tail_time != 0) begin
            // time runs backwards
            stamp = (tail_time > 16 && q < 8) ? tail_time - $urandom_range(1, 16)
                                              : stamp % tail_time;
            send_item(MODE_APPEND, stamp, iter, HANDLE_W'($urandom), read_pos);
         end else begin
            send_wellformed(next_append_time(), next_append_iter());
         end
      end else if (r < 77) begin
         if (n > 0) begin
            case (q)
               0, 1:    stamp = sb.time_log[k];
               2, 3:    stamp = sb.time_log[k] + 1;
               4:       stamp = sb.time_log[k] - 1;
               5:       stamp = sb.time_log[0];
               6:       stamp = sb.time_log[n-1];
               7:       stamp = sb.time_log[k] + $urandom;
               default: ;
            endcase
         end
         send_item(MODE_TIME, stamp, iter, HANDLE_W'($urandom), read_pos);
      end else if (r < 89) begin
         if (n > 0) begin
            case (q)
               0, 1:    iter = sb.iter_log[k];
               2:       iter = sb.iter_log[k] + 1;
               3:       iter = sb.iter_log[k] - 1;
               4:       iter = sb.iter_log[0];
               5:       iter = sb.iter_log[n-1];
               6:       iter = '0;
               7:       iter = '1;
               default: ;
            endcase
         end
         send_item(MODE_ITER, stamp, iter, HANDLE_W'($urandom), read_pos);
      end else begin
         case (q)
            4, 5, 6: read_pos = RIDX_W'(k);
            7:       read_pos = RIDX_W'(n);
            8:       read_pos = RIDX_W'(n - 1);
            9:       read_pos = '1;
            default: ;
         endcase
         send_item(MODE_INDEX, stamp, iter, HANDLE_W'($urandom), read_pos);
      end
   endtask

   initial begin
      int idle_set  [4];
      int stall_set [4];
      idle_set  = '{0, 72, 0, 30};
      stall_set = '{0, 0, 72, 30};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lookups on the empty log
      send_item(MODE_TIME,  '0, '0, '0, '0);
      send_item(MODE_TIME,  '1, '1, '1, '1);
      send_item(MODE_ITER,  '0, '0, '0, '0);
      send_item(MODE_ITER,  '1, '1, '1, '1);
      send_item(MODE_INDEX, '0, '0, '0, '0);
      send_item(MODE_INDEX, '1, '1, '1, '1);
      // appends: accepted, time backwards, iteration backwards, zero iteration skip
      send_item(MODE_APPEND, 48'h0,       32'd2, 16'h0000, '0);
      send_item(MODE_APPEND, 48'h1_0000,  32'd5, 16'hFFFF, '1);
      send_item(MODE_APPEND, 48'h0,       32'd9, 16'h0001, '0);
      send_item(MODE_APPEND, 48'h2_0000,  32'd3, 16'h0002, '0);
      send_item(MODE_APPEND, 48'h2_0000,  32'd0, 16'h0003, '0);
      send_item(MODE_APPEND, 48'h2_0000,  32'd4, 16'h0004, '0);
      send_item(MODE_APPEND, 48'h3_8000,  32'd4, 16'h0005, '0);
      // time lookups: clamp low, clamp at last, clamp high, inside, duplicate times
      send_item(MODE_TIME, 48'h0,      '0, '0, '0);
      send_item(MODE_TIME, 48'h3_8000, '0, '0, '0);
      send_item(MODE_TIME, '1,         '0, '0, '0);
      send_item(MODE_TIME, 48'h1_8000, '0, '0, '0);
      send_item(MODE_TIME, 48'h2_0000, '0, '0, '0);
      // iteration lookups: below first, a stored value above last, top of field, non-monotone stored zero
      send_item(MODE_ITER, '0, 32'd1, '0, '0);
      send_item(MODE_ITER, '0, 32'd5, '0, '0);
      send_item(MODE_ITER, '0, '1,    '0, '0);
      send_item(MODE_ITER, '0, 32'd4, '0, '0);
      // reads inside, at the count, at the top of the field
      send_item(MODE_INDEX, '0, '0, '0, 10'd2);
      send_item(MODE_INDEX, '0, '0, '0, 10'd5);
      send_item(MODE_INDEX, '0, '0, '0, '1);
      settle_log();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_set[phase];
         recv_stall_pct = stall_set[phase];
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
         settle_log();
      end

      // fill the table, last entry at the top of time and iteration
      while (planned_count < DEPTH) begin
         if (planned_count == DEPTH - 1) begin
            send_wellformed('1, '1);
         end else begin
            send_wellformed(next_append_time(), next_append_iter());
         end
      end
      send_wellformed('1, '1);
      send_item(MODE_INDEX, '0, '0, '0, '1);
      send_item(MODE_TIME, '1, '0, '0, '0);
      send_item(MODE_ITER, '0, '1, '0, '0);
      for (int i = 0; i < 12; i++) send_random_item();

      settle_log();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d transactions over four handshake pressure phases, %0d results checked",
               items_sent, sb.checked);
      $display("log ended with %0d of %0d entries, %0d mismatches", sb.count, DEPTH, sb.errors);
      if (sb.errors == 0 && sb.expected_lookups.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/tilog_pkg.sv
hw/rtl/tilog_ram.sv
hw/rtl/time_indexed_log_search_core.sv
tb/tilog_check_pkg.sv
tb/tb_top.sv
